// ===== src/page_frame_bitmap_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the page frame bitmap allocator
// Concurrent checks in simulation; empty bodies in synthesis.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, off during reset.
`define PFBA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on clk, off during reset.
`define PFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFBA_ASSERT_IMPL(lbl, ante, cons, msg)
`define PFBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared constants, request codes and transaction structs of the allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

    localparam int REQ_W      = 2;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int ADDR_W     = 24;
    localparam int PAGE_SHIFT = 12;   // 4096-byte pages
    localparam int WORD_W     = 32;
    localparam int WORD_SHIFT = 5;

    localparam logic [WORD_W-1:0] FULL_WORD         = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0]  FRAME_COUNT_RESET = 13'd4096;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MARK    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [IDX_W-1:0] frame_index;
    } request_t;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        logic              ok;
    } result_t;

endpackage

// ===== src/pfba_engine.sv =====
// ----------------------------------------------------------------------------
// pfba_engine
// Bitmap memory with clearing pass, read-modify-write sequencer and
// lowest-free-word hint.
// ----------------------------------------------------------------------------
`include "page_frame_bitmap_allocator_top_macros.svh"

module pfba_engine #(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pfba_pkg::CNT_W-1:0]    frame_count,
    input  logic                          req_valid,
    input  pfba_pkg::request_t            req,
    output logic                          req_stall,
    output logic                          res_valid,
    output pfba_pkg::result_t             res,
    input  logic                          res_take
);

    localparam int WS        = pfba_pkg::WORD_SHIFT;
    localparam int MAP_WORDS = (MAX_FRAMES + pfba_pkg::WORD_W - 1) / pfba_pkg::WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int HW        = AW + 1;
    localparam int FW        = AW + WS;
    localparam int CW        = (AW + WS + 1 > pfba_pkg::CNT_W) ? AW + WS + 1 : pfba_pkg::CNT_W;
    localparam int FB        = pfba_pkg::ADDR_W - pfba_pkg::PAGE_SHIFT;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_RESULT
    } state_t;

    state_t                       state_reg, state_next;
    logic [pfba_pkg::REQ_W-1:0]   type_reg, type_next;
    logic [pfba_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [AW-1:0]                addr_reg, addr_next;
    logic [HW-1:0]                hint_reg, hint_next;
    logic [AW-1:0]                clr_reg, clr_next;
    pfba_pkg::result_t            res_reg, res_next;

    logic [pfba_pkg::WORD_W-1:0]  map_mem [MAP_WORDS];
    logic [pfba_pkg::WORD_W-1:0]  rdata_reg;
    logic                         mem_we;
    logic                         mem_re;
    logic [AW-1:0]                mem_waddr;
    logic [pfba_pkg::WORD_W-1:0]  mem_wdata;

    logic [CW-1:0]                max_c;
    logic [CW-1:0]                cnt_ext;
    logic [CW-1:0]                limit;
    logic [CW-1:0]                idx_ext;
    logic [CW-1:0]                hint_base;
    logic [HW-1:0]                scan_next;
    logic [CW-1:0]                scan_base;
    logic [pfba_pkg::WORD_W-1:0]  free_bits;
    logic [pfba_pkg::WORD_W-1:0]  lowest_free;
    logic [WS-1:0]                free_pos;
    logic [CW-1:0]                found_ext;
    logic [pfba_pkg::WORD_W-1:0]  idx_mask;
    logic [pfba_pkg::WORD_W-1:0]  alloc_mask;

    // Active frame count, saturated to the map size
    assign max_c     = CW'(MAX_FRAMES);
    assign cnt_ext   = CW'(frame_count);
    assign limit     = (cnt_ext > max_c) ? max_c : cnt_ext;
    assign idx_ext   = CW'(req.frame_index);
    assign hint_base = CW'({hint_reg, {WS{1'b0}}});
    assign scan_next = {1'b0, addr_reg} + HW'(1);
    assign scan_base = CW'({scan_next, {WS{1'b0}}});

    // Isolate the lowest clear bit of the word just read
    assign free_bits   = ~rdata_reg;
    assign lowest_free = free_bits & (~free_bits + pfba_pkg::WORD_W'(1));

    always_comb
    begin
        free_pos = '0;
        for (int i = 0; i < pfba_pkg::WORD_W; i++)
        begin
            if (lowest_free[i])
            begin
                free_pos = free_pos | WS'(i);
            end
        end
    end

    assign found_ext  = CW'({addr_reg, free_pos});
    assign idx_mask   = pfba_pkg::WORD_W'(1) << idx_reg[WS-1:0];
    assign alloc_mask = pfba_pkg::WORD_W'(1) << free_pos;

    always_comb
    begin
        state_next = state_reg;
        type_next  = type_reg;
        idx_next   = idx_reg;
        addr_next  = addr_reg;
        hint_next  = hint_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = rdata_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    type_next  = req.req_type;
                    idx_next   = req.frame_index;
                    res_next   = '0;
                    state_next = ST_RESULT;
                    case (req.req_type)
                        pfba_pkg::REQ_ALLOC:
                        begin
                            // start the scan at the lowest word that may hold a free bit
                            if (hint_base < limit)
                            begin
                                addr_next  = hint_reg[AW-1:0];
                                state_next = ST_READ;
                            end
                        end
                        pfba_pkg::REQ_MARK, pfba_pkg::REQ_RELEASE:
                        begin
                            if (idx_ext < limit)
                            begin
                                addr_next  = idx_ext[AW+WS-1:WS];
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                state_next = ST_RESULT;
                case (type_reg)
                    pfba_pkg::REQ_MARK:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rdata_reg | idx_mask;
                        res_next.ok = 1'b1;
                    end
                    pfba_pkg::REQ_RELEASE:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rdata_reg & ~idx_mask;
                        res_next.ok = 1'b1;
                        if ({1'b0, addr_reg} < hint_reg)
                        begin
                            hint_next = {1'b0, addr_reg};
                        end
                    end
                    default:
                    begin
                        if (rdata_reg == pfba_pkg::FULL_WORD)
                        begin
                            // word full: advance the hint and read the next word if it lies below the limit
                            hint_next = scan_next;
                            if (scan_base < limit)
                            begin
                                addr_next  = scan_next[AW-1:0];
                                state_next = ST_READ;
                            end
                        end
                        else
                        begin
                            hint_next = {1'b0, addr_reg};
                            if (found_ext < limit)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = rdata_reg | alloc_mask;
                                res_next.frame_address =
                                    {found_ext[FB-1:0], {pfba_pkg::PAGE_SHIFT{1'b0}}};
                                res_next.ok = 1'b1;
                            end
                        end
                    end
                endcase
            end

            ST_RESULT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            type_reg  <= '0;
            idx_reg   <= '0;
            addr_reg  <= '0;
            hint_reg  <= '0;
            clr_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            type_reg  <= type_next;
            idx_reg   <= idx_next;
            addr_reg  <= addr_next;
            hint_reg  <= hint_next;
            clr_reg   <= clr_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= map_mem[addr_reg];
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

    `PFBA_ASSERT_IMPL(a_hint_range, 1'b1, hint_reg <= HW'(MAP_WORDS), "hint beyond map")
    `PFBA_ASSERT_IMPL(a_write_range, mem_we, {1'b0, mem_waddr} < HW'(MAP_WORDS), "map write out of range")
    `PFBA_ASSERT_NEXT(a_accept_next, req_valid && !req_stall, state_reg == ST_READ || state_reg == ST_RESULT, "bad state after accept")
    `PFBA_ASSERT_IMPL(a_fail_zero, res_valid && !res.ok, res.frame_address == '0, "failed request with nonzero address")

endmodule

// ===== src/page_frame_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_top
// Bitmap physical frame allocator with one result per request.
// ----------------------------------------------------------------------------
// The allocator keeps one usage bit per physical frame in a single-port
// memory of 32-bit words and serves one request at a time. Allocate returns
// the lowest free frame below frame_count (saturated to MAX_FRAMES) as a byte
// address, frame times 4096; mark and release set or clear one frame's bit.
// After reset the map is swept to zero, one word per cycle; in_stall stays
// high during that pass, while frame_count writes are taken as ever. Each
// request is a read-modify-write of one map word: mark, release and an
// allocate whose first word has room pass through the read, check and
// result states, and the next request is taken once the result has moved
// on to the output register. An allocate walks up from the lowest word
// that may still hold a free bit and repeats read, then check, for every
// full word it skips. Rejected requests go from idle straight to the
// result state. The result waits in an output register, so the next
// request is accepted while the receiver stalls.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_top #(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request transaction
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pfba_pkg::REQ_W-1:0]     req_type,
    input  logic [pfba_pkg::IDX_W-1:0]     frame_index,
    // result transaction
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pfba_pkg::ADDR_W-1:0]    frame_address,
    output logic                           ok,
    // configuration write transaction
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pfba_pkg::CNT_W-1:0]     frame_count
);

    logic [pfba_pkg::CNT_W-1:0] count_reg;
    pfba_pkg::request_t         eng_req;
    pfba_pkg::result_t          eng_res;
    logic                       eng_res_valid;
    logic                       out_free;
    logic                       out_load;
    logic                       out_valid_reg, out_valid_next;
    pfba_pkg::result_t          out_reg, out_next;

    // Config writes land at once; the port never pushes back
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= pfba_pkg::FRAME_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= frame_count;
        end
    end

    assign eng_req.req_type    = req_type;
    assign eng_req.frame_index = frame_index;

    pfba_engine #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_count (count_reg),
        .req_valid   (in_valid),
        .req         (eng_req),
        .req_stall   (in_stall),
        .res_valid   (eng_res_valid),
        .res         (eng_res),
        .res_take    (out_free)
    );

    // Output register: free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = eng_res_valid && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = eng_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_address = out_reg.frame_address;
    assign ok            = out_reg.ok;

endmodule
